// ===== sv/ngar_pkg.sv =====
// ngar_pkg: shared types, widths, register indexes and the saturating rejoin
`default_nettype none
package ngar_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 8;
  localparam int ELAPSED_W = 17;
  localparam int RAMP_W    = 16;
  localparam int THRESH_W  = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DVD_W     = ELAPSED_W + GAIN_FRAC;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int PROD_W    = SAMPLE_W + GAIN_W;
  localparam int SCALED_W  = PROD_W - GAIN_FRAC;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    MODE_BYPASS  = 2'd0,
    MODE_ATTACK  = 2'd1,
    MODE_ACTIVE  = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = CFG_IDX_W'(2);

  localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = THRESH_W'(10000);
  localparam logic [RAMP_W-1:0]    ATTACK_RESET    = RAMP_W'(2205);
  localparam logic [RAMP_W-1:0]    RELEASE_RESET   = RAMP_W'(2205);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = {ELAPSED_W{1'b1}};

  // sign and magnitude back to a saturated two's complement sample
  function automatic logic [SAMPLE_W-1:0] join_sat(input logic neg,
                                                   input logic [SCALED_W-1:0] mag);
    logic [SCALED_W-1:0] lim;
    logic [SCALED_W-1:0] m;
    logic [SAMPLE_W-1:0] r;
    lim = SCALED_W'(1) << (SAMPLE_W - 1);
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      r = ~m[SAMPLE_W-1:0] + SAMPLE_W'(1);
    end else begin
      m = (mag > lim - SCALED_W'(1)) ? lim - SCALED_W'(1) : mag;
      r = m[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ngar_if.sv =====
// ngar_if: valid/ready channels for stereo sample words and gated result words
`default_nettype none
interface ngar_in_if;
  logic                     valid;
  logic                     ready;
  ngar_pkg::sample_t        left_sample;
  ngar_pkg::sample_t        right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface ngar_out_if;
  logic                     valid;
  logic                     ready;
  ngar_pkg::sample_t        left_out;
  ngar_pkg::sample_t        right_out;
  logic [1:0]               gate_mode;

  modport source (output valid, output left_out, output right_out, output gate_mode,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input gate_mode,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/ngar_div.sv =====
// ngar_div: radix-2 restoring divider for the ramp gain, one quotient bit per cycle
`default_nettype none
module ngar_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ngar_pkg::ELAPSED_W-1:0] num,
  input  wire logic [ngar_pkg::RAMP_W-1:0]   den,
  output logic                               done,
  output logic [ngar_pkg::GAIN_W-1:0]        gain
);

  logic [ngar_pkg::DVD_W-1:0]     dvd;
  logic [ngar_pkg::DVD_W-1:0]     quot;
  logic [ngar_pkg::RAMP_W-1:0]    rem;
  logic [ngar_pkg::RAMP_W-1:0]    den_r;
  logic [ngar_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [ngar_pkg::RAMP_W:0]      rem_sh;
  logic                           ge;

  assign rem_sh = {rem, dvd[ngar_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= ngar_pkg::DIV_CNT_W'(ngar_pkg::DVD_W);
        dvd   <= {num, {ngar_pkg::GAIN_FRAC{1'b0}}};
        den_r <= den;
        rem   <= '0;
        quot  <= '0;
      end else if (busy) begin
        dvd  <= {dvd[ngar_pkg::DVD_W-2:0], 1'b0};
        quot <= {quot[ngar_pkg::DVD_W-2:0], ge};
        rem  <= ge ? ngar_pkg::RAMP_W'(rem_sh - {1'b0, den_r})
                   : rem_sh[ngar_pkg::RAMP_W-1:0];
        cnt  <= cnt - ngar_pkg::DIV_CNT_W'(1);
        if (cnt == ngar_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // gain clamps at its top code
  assign gain = (|quot[ngar_pkg::DVD_W-1:ngar_pkg::GAIN_W]) ? {ngar_pkg::GAIN_W{1'b1}}
                                                            : quot[ngar_pkg::GAIN_W-1:0];

endmodule
`default_nettype wire

// ===== sv/ngar_scale.sv =====
// ngar_scale: registered magnitude-by-gain product and saturating sign restore
`default_nettype none
module ngar_scale (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         neg,
  input  wire logic [ngar_pkg::SAMPLE_W-1:0] mag,
  input  wire logic [ngar_pkg::GAIN_W-1:0]  gain,
  output logic [ngar_pkg::SAMPLE_W-1:0]     scaled
);

  logic [ngar_pkg::PROD_W-1:0] prod;
  logic                        neg_r;

  always_ff @(posedge clk) begin
    if (load) begin
      prod  <= ngar_pkg::PROD_W'(mag) * ngar_pkg::PROD_W'(gain);
      neg_r <= neg;
    end
  end

  assign scaled = ngar_pkg::join_sat(neg_r, prod[ngar_pkg::PROD_W-1:ngar_pkg::GAIN_FRAC]);

endmodule
`default_nettype wire

// ===== sv/noise_gate_attack_release.sv =====
// noise_gate_attack_release: stereo noise gate with attack and release gain ramps
//
// samples (sink) takes one stereo word per handshake; results (source) gives one
// word per input word: gated left, right (passed in bypass, else a copy of left)
// and the gate mode after that word. The config port writes gate threshold (0),
// attack length (1) and release length (2) on cfg_write; other indexes are ignored.
// Bypass and mute words go from accept straight to the done state. Ramp words
// run the gain division through a one-bit-per-cycle divider (33 steps) and then
// the multiply state before the done state; the next word can be taken in the
// cycle after the result is registered. One word is in work at a time;
// samples.ready is high only between words.
// A finished word waits in the result register while results.ready is low;
// the next input word may be accepted meanwhile, and is held before its result
// register load until the previous word is taken.
// Reset (rst, synchronous) returns the gate to bypass, clears the elapsed count
// and the result valid, and reloads threshold 10000 and both ramp lengths 2205.
`default_nettype none
module noise_gate_attack_release (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ngar_in_if.sink                             samples,
  ngar_out_if.source                          results,
  input  wire logic                           cfg_write,
  input  wire logic [ngar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ngar_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                            state;
  ngar_pkg::mode_t                   mode;
  ngar_pkg::mode_t                   mode_next;
  logic [ngar_pkg::ELAPSED_W-1:0]    elapsed;
  logic [ngar_pkg::ELAPSED_W-1:0]    elapsed_next;
  logic [ngar_pkg::THRESH_W-1:0]     threshold;
  logic [ngar_pkg::RAMP_W-1:0]       attack_len;
  logic [ngar_pkg::RAMP_W-1:0]       release_len;

  logic                              accept;
  logic                              neg;
  logic [ngar_pkg::SAMPLE_W-1:0]     mag;
  logic [ngar_pkg::RAMP_W-1:0]       a_eff;
  logic [ngar_pkg::RAMP_W-1:0]       r_eff;
  logic [ngar_pkg::ELAPSED_W-1:0]    num;
  logic [ngar_pkg::RAMP_W-1:0]       den;
  logic                              do_ramp;
  logic [ngar_pkg::SAMPLE_W-1:0]     pass_left;
  logic [ngar_pkg::SAMPLE_W-1:0]     pass_right;

  logic                              lat_neg;
  logic [ngar_pkg::SAMPLE_W-1:0]     lat_mag;
  logic [ngar_pkg::SAMPLE_W-1:0]     res_left;
  logic [ngar_pkg::SAMPLE_W-1:0]     res_right;
  ngar_pkg::mode_t                   res_mode;
  logic                              out_valid;
  logic                              out_free;

  logic                              div_done;
  logic [ngar_pkg::GAIN_W-1:0]       div_gain;
  logic [ngar_pkg::SAMPLE_W-1:0]     scaled;

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !out_valid || results.ready;

  always_comb begin
    logic [ngar_pkg::ELAPSED_W-1:0] e_clr;
    neg        = samples.left_sample[ngar_pkg::SAMPLE_W-1];
    mag        = neg ? ngar_pkg::SAMPLE_W'(-samples.left_sample) : samples.left_sample;
    a_eff      = (attack_len == '0) ? ngar_pkg::RAMP_W'(1) : attack_len;
    r_eff      = (release_len == '0) ? ngar_pkg::RAMP_W'(1) : release_len;
    mode_next  = mode;
    e_clr      = elapsed;
    num        = elapsed;
    den        = r_eff;
    do_ramp    = 1'b0;
    pass_left  = samples.left_sample;
    pass_right = samples.right_sample;
    unique case (mode)
      ngar_pkg::MODE_BYPASS: begin
        if (mag < {1'b0, threshold}) begin
          mode_next = ngar_pkg::MODE_ATTACK;
          e_clr     = '0;
        end
      end
      ngar_pkg::MODE_ATTACK: begin
        do_ramp = 1'b1;
        den     = a_eff;
        num     = (elapsed >= ngar_pkg::ELAPSED_W'(a_eff))
                  ? elapsed - ngar_pkg::ELAPSED_W'(a_eff)
                  : ngar_pkg::ELAPSED_W'(a_eff) - elapsed;
        if (elapsed > ngar_pkg::ELAPSED_W'(a_eff)) mode_next = ngar_pkg::MODE_ACTIVE;
      end
      ngar_pkg::MODE_ACTIVE: begin
        pass_left  = '0;
        pass_right = '0;
        if (mag > {1'b0, threshold}) begin
          mode_next = ngar_pkg::MODE_RELEASE;
          e_clr     = '0;
        end
      end
      ngar_pkg::MODE_RELEASE: begin
        do_ramp = 1'b1;
        if (elapsed > ngar_pkg::ELAPSED_W'(r_eff)) mode_next = ngar_pkg::MODE_BYPASS;
      end
      default: ;
    endcase
    elapsed_next = (e_clr < ngar_pkg::ELAPSED_MAX) ? e_clr + ngar_pkg::ELAPSED_W'(1) : e_clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= ngar_pkg::THRESHOLD_RESET;
      attack_len  <= ngar_pkg::ATTACK_RESET;
      release_len <= ngar_pkg::RELEASE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ngar_pkg::REG_THRESHOLD: threshold   <= cfg_data[ngar_pkg::THRESH_W-1:0];
        ngar_pkg::REG_ATTACK:    attack_len  <= cfg_data[ngar_pkg::RAMP_W-1:0];
        ngar_pkg::REG_RELEASE:   release_len <= cfg_data[ngar_pkg::RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= ngar_pkg::MODE_BYPASS;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode      <= mode_next;
            elapsed   <= elapsed_next;
            res_mode  <= mode_next;
            res_left  <= pass_left;
            res_right <= pass_right;
            lat_neg   <= neg;
            lat_mag   <= mag;
            state     <= do_ramp ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_MUL;
        end
        ST_MUL: begin
          res_left  <= scaled;
          res_right <= scaled;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            results.left_out  <= res_left;
            results.right_out <= res_right;
            results.gate_mode <= res_mode;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid = out_valid;

  ngar_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept && do_ramp),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .gain  (div_gain)
  );

  ngar_scale u_scale (
    .clk    (clk),
    .load   (div_done),
    .neg    (lat_neg),
    .mag    (lat_mag),
    .gain   (div_gain),
    .scaled (scaled)
  );

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_mul_after_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> $past(state) == ST_DIV)
    else $error("multiply phase not entered from divide phase");

  a_elapsed_steps: assert property (@(posedge clk) disable iff (rst)
    elapsed != $past(elapsed) |->
      elapsed == $past(elapsed) + ngar_pkg::ELAPSED_W'(1) ||
      elapsed == ngar_pkg::ELAPSED_W'(1))
    else $error("elapsed count moved other than by one or restart");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && !results.ready |=> out_valid && state == ST_DONE)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for the noise gate, random stereo words checked against a mode predictor
`timescale 1ns / 1ps
module tb;
  import ngar_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam logic [63:0] GAIN_MAX    = (64'd1 << GAIN_W) - 64'd1;
  localparam logic [63:0] SAT_LIM     = 64'd1 << (SAMPLE_W - 1);
  localparam int          LONG_HOLD   = 300;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          WORD_TARGET = 950;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_word_t;

  typedef struct {
    sample_t left;
    sample_t right;
    mode_t   mode;
  } gated_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ngar_in_if  samples_ch ();
  ngar_out_if results_ch ();

  noise_gate_attack_release i_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_ch),
    .results   (results_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted gate state and register copies
  mode_t                gate_mode_q  = MODE_BYPASS;
  logic [ELAPSED_W-1:0] elapsed_q    = '0;
  logic [THRESH_W-1:0]  threshold_q  = THRESHOLD_RESET;
  logic [RAMP_W-1:0]    attack_len_q = ATTACK_RESET;
  logic [RAMP_W-1:0]    release_len_q = RELEASE_RESET;

  stereo_word_t stereo_backlog[$];
  gated_word_t  gated_due[$];
  stereo_word_t tx_word;
  gated_word_t  rx_want;

  int words_queued  = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int tx_gap        = 0;
  int tx_streak     = 0;
  int rx_stall      = 0;
  int rx_streak     = 0;
  logic [7:0] hold_req  = '0;
  logic [7:0] hold_seen = '0;

  function automatic sample_t ramp_scale(input logic neg, input logic [ELAPSED_W-1:0] mag,
                                         input logic [ELAPSED_W-1:0] num,
                                         input logic [ELAPSED_W-1:0] den);
    logic [63:0] gain;
    logic [63:0] scaled;
    gain = (64'(num) << GAIN_FRAC) / 64'(den);
    if (gain > GAIN_MAX) gain = GAIN_MAX;
    scaled = (64'(mag) * gain) >> GAIN_FRAC;
    if (neg) begin
      if (scaled > SAT_LIM) scaled = SAT_LIM;
      return sample_t'(64'd0 - scaled);
    end
    if (scaled > SAT_LIM - 64'd1) scaled = SAT_LIM - 64'd1;
    return sample_t'(scaled);
  endfunction

  function automatic gated_word_t gate_word(input sample_t l, input sample_t r);
    gated_word_t o;
    logic [ELAPSED_W-1:0] mag;
    logic [ELAPSED_W-1:0] e;
    logic [ELAPSED_W-1:0] a;
    logic [ELAPSED_W-1:0] rl;
    mag = l[SAMPLE_W-1] ? ELAPSED_W'(-int'(l)) : ELAPSED_W'(int'(l));
    e = elapsed_q;
    a = (attack_len_q == '0) ? ELAPSED_W'(1) : ELAPSED_W'(attack_len_q);
    rl = (release_len_q == '0) ? ELAPSED_W'(1) : ELAPSED_W'(release_len_q);
    o.left = l;
    o.right = r;
    case (gate_mode_q)
      MODE_BYPASS: begin
        if (mag < ELAPSED_W'(threshold_q)) begin
          gate_mode_q = MODE_ATTACK;
          elapsed_q = '0;
        end
      end
      MODE_ATTACK: begin
        o.left = ramp_scale(l[SAMPLE_W-1], mag, (e >= a) ? e - a : a - e, a);
        o.right = o.left;
        if (e > a) gate_mode_q = MODE_ACTIVE;
      end
      MODE_ACTIVE: begin
        o.left = '0;
        o.right = '0;
        if (mag > ELAPSED_W'(threshold_q)) begin
          gate_mode_q = MODE_RELEASE;
          elapsed_q = '0;
        end
      end
      default: begin
        o.left = ramp_scale(l[SAMPLE_W-1], mag, e, rl);
        o.right = o.left;
        if (e > rl) gate_mode_q = MODE_BYPASS;
      end
    endcase
    if (elapsed_q != ELAPSED_MAX) elapsed_q = elapsed_q + ELAPSED_W'(1);
    o.mode = gate_mode_q;
    return o;
  endfunction

  function automatic int next_gap(inout int streak);
    int r;
    if (streak > 0) begin
      streak = streak - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      streak = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // left sample below, at or above the current threshold
  function automatic sample_t make_left(input bit quiet);
    int mag;
    bit neg;
    neg = $urandom_range(0, 1);
    if (quiet && threshold_q != '0) mag = $urandom_range(0, int'(threshold_q) - 1);
    else if ($urandom_range(0, 19) == 0) mag = int'(threshold_q);
    else mag = $urandom_range(int'(threshold_q) + 1, 32768);
    if (mag == 32768) neg = 1'b1;
    return sample_t'(neg ? -mag : mag);
  endfunction

  function automatic logic [CFG_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom_range(100, 3000));
      default: return CFG_W'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic note_error(input string msg);
    if (mismatches < 40) $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_word(input sample_t l, input sample_t r);
    stereo_backlog.push_back('{left: l, right: r});
    words_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_THRESHOLD: threshold_q = data[THRESH_W-1:0];
      REG_ATTACK:    attack_len_q = data;
      REG_RELEASE:   release_len_q = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    while (words_checked != words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    int run_left;
    int kind;
    run_left = 0;
    kind = 0;
    repeat (n) begin
      if (run_left == 0) begin
        kind = $urandom_range(0, 9);
        run_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 12);
      end
      run_left--;
      queue_word((kind == 0) ? sample_t'($urandom) : make_left(kind < 5), sample_t'($urandom));
    end
  endtask

  task automatic steer_to(input mode_t target);
    while (gate_mode_q != target) begin
      queue_word(make_left(gate_mode_q == MODE_BYPASS), sample_t'($urandom));
      settle();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (samples_ch.valid && samples_ch.ready)
        gated_due.push_back(gate_word(samples_ch.left_sample, samples_ch.right_sample));
      if (!samples_ch.valid || samples_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          samples_ch.valid <= 1'b0;
        end else if (stereo_backlog.size() != 0) begin
          tx_word = stereo_backlog.pop_front();
          samples_ch.valid <= 1'b1;
          samples_ch.left_sample <= tx_word.left;
          samples_ch.right_sample <= tx_word.right;
          tx_gap = next_gap(tx_streak);
        end else begin
          samples_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        if (gated_due.size() == 0) begin
          note_error("result word with nothing expected");
        end else begin
          rx_want = gated_due.pop_front();
          if (results_ch.left_out != rx_want.left)
            note_error($sformatf("left_out %0d, expected %0d", results_ch.left_out,
                                 rx_want.left));
          if (results_ch.right_out != rx_want.right)
            note_error($sformatf("right_out %0d, expected %0d", results_ch.right_out,
                                 rx_want.right));
          if (results_ch.gate_mode != rx_want.mode)
            note_error($sformatf("gate_mode %0d, expected %0d", results_ch.gate_mode,
                                 rx_want.mode));
        end
        words_checked++;
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        rx_stall = LONG_HOLD;
        results_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
        rx_stall = next_gap(rx_streak);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase_no;
    phase_no = 0;
    samples_ch.valid = 1'b0;
    samples_ch.left_sample = '0;
    samples_ch.right_sample = '0;
    results_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes in bypass, then into a long attack ramp
    queue_word(16'sh7FFF, 16'sh7FFF);
    queue_word(16'sh8000, 16'sh8000);
    queue_word(16'sh0000, 16'sh1234);
    queue_word(16'sh7FFF, 16'sh0000);
    queue_word(16'sh8000, -16'sh0001);
    queue_word(-16'sh0001, 16'sh0001);
    queue_word(16'sh0001, 16'sh5555);
    settle();

    // zero ramp lengths, masked threshold, spare index
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_ATTACK, 16'h0000);
    write_reg(REG_RELEASE, 16'h0000);
    write_reg(REG_SPARE, 16'hFFFF);
    queue_word(16'sh8000, 16'sh2AAA);
    queue_word(16'sh7FFF, 16'sh0F0F);
    queue_word(16'sh8000, 16'sh0000);
    queue_word(16'sh0064, 16'sh7FFF);
    queue_word(-16'sh0064, 16'sh8000);
    queue_word(16'sh7FFF, 16'sh0001);
    queue_word(16'sh0000, 16'sh1111);
    queue_word(16'sh4000, 16'sh2222);
    queue_word(16'sh8000, 16'sh3333);
    queue_word(16'sh7FFF, 16'sh4444);
    settle();

    write_reg(REG_THRESHOLD, 16'h0000);
    queue_word(16'sh0000, 16'sh0000);
    queue_word(16'sh0001, -16'sh0001);
    settle();

    // long release ramp, then the ramp length cut so the gain overflows
    write_reg(REG_THRESHOLD, 16'd5000);
    write_reg(REG_ATTACK, 16'd2);
    write_reg(REG_RELEASE, 16'd3);
    steer_to(MODE_RELEASE);
    write_reg(REG_RELEASE, 16'hFFFF);
    run_phase(280);
    settle();
    write_reg(REG_RELEASE, 16'h0000);
    run_phase(12);
    settle();

    while (words_queued < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_THRESHOLD, '0);
        1: write_reg(REG_THRESHOLD, '1);
        2: write_reg(REG_THRESHOLD, CFG_W'($urandom));
        default: write_reg(REG_THRESHOLD, CFG_W'($urandom_range(200, 20000)));
      endcase
      write_reg(REG_ATTACK, pick_length());
      write_reg(REG_RELEASE, pick_length());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
      if (phase_no % 6 == 1) hold_req <= hold_req + 8'd1;
      run_phase($urandom_range(20, 60));
      settle();
      phase_no++;
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== noise_gate_attack_release.f =====
sv/ngar_pkg.sv
sv/ngar_if.sv
sv/ngar_div.sv
sv/ngar_scale.sv
sv/noise_gate_attack_release.sv
bench/tb.sv
